### rtl/btlv_pkg.sv
// Shared types and constants for the BER TLV element parser.
// Used by every module under rtl/; depends on nothing.
package btlv_pkg;

  localparam int MAX_TAG_BYTES_DEF    = 3;
  localparam int MAX_LENGTH_BYTES_DEF = 3;
  localparam int COUNT_BITS_DEF       = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam int TAG_W       = 24;
  localparam int LEN_OUT_W   = 16;
  localparam int OUT_TDATA_W = 56;

  localparam logic [7:0] LONG_TAG_MASK = 8'h1F;
  localparam logic [7:0] INDEF_LEN     = 8'h80;
  localparam logic [LEN_OUT_W-1:0] LEN_OUT_MAX = 16'hFFFF;

  localparam logic [2:0] ROLE_TAG     = 3'd0;
  localparam logic [2:0] ROLE_LEN     = 3'd1;
  localparam logic [2:0] ROLE_CONTENT = 3'd2;
  localparam logic [2:0] ROLE_EOC     = 3'd3;
  localparam logic [2:0] ROLE_DROP    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_TAG_LONG = 2'd2;
  localparam logic [1:0] ST_LEN_LONG = 2'd3;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_TAGX  = 3'd1,
    PH_LEN   = 3'd2,
    PH_LENX  = 3'd3,
    PH_BODY  = 3'd4,
    PH_INDEF = 3'd5,
    PH_DROP  = 3'd6
  } phase_t;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       bend;
    logic       long_tag;
    logic       hi_bit;
    logic       is_zero;
    logic       is_indef;
    logic       len_too_long;
    logic [6:0] len_n;
  } cls_t;

endpackage

### rtl/btlv_front.sv
// Front end: classifies each incoming byte for the parser back end.
// Uses btlv_pkg (cls_t, constants).
module btlv_front #(
  parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic [7:0]    byte_i,
  input  logic          start_i,
  input  logic          bend_i,
  output btlv_pkg::cls_t word_o
);

  always_comb begin
    word_o.data         = byte_i;
    word_o.start        = start_i;
    word_o.bend         = bend_i;
    word_o.long_tag     = (byte_i & btlv_pkg::LONG_TAG_MASK) == btlv_pkg::LONG_TAG_MASK;
    word_o.hi_bit       = byte_i[7];
    word_o.is_zero      = byte_i == 8'h00;
    word_o.is_indef     = byte_i == btlv_pkg::INDEF_LEN;
    word_o.len_n        = byte_i[6:0];
    word_o.len_too_long = byte_i[6:0] >= 7'(MAX_LENGTH_BYTES);
  end

endmodule

### rtl/btlv_fifo.sv
// Short queue of classified words between front end and parser.
// Uses btlv_pkg (cls_t, QUEUE_DEPTH).
module btlv_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  btlv_pkg::cls_t wdata_i,
  input  logic           pop_i,
  output btlv_pkg::cls_t rdata_o,
  output logic           full_o,
  output logic           valid_o
);

  localparam int PTR_W = (btlv_pkg::QUEUE_DEPTH > 1) ? $clog2(btlv_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(btlv_pkg::QUEUE_DEPTH + 1);

  btlv_pkg::cls_t    mem_r [btlv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(btlv_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push_i ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  assign rdata_o = mem_r[rd_ptr_r];
  assign full_o  = count_r == CNT_W'(btlv_pkg::QUEUE_DEPTH);
  assign valid_o = count_r != '0;

endmodule

### rtl/btlv_back.sv
// Back end: TLV parse state machine and registered result stage.
// Uses btlv_pkg (phase_t, cls_t, role and status codes).
module btlv_back #(
  parameter int MAX_TAG_BYTES    = btlv_pkg::MAX_TAG_BYTES_DEF,
  parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int COUNT_BITS       = btlv_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btlv_pkg::cls_t                      word_i,
  input  logic                                word_valid_i,
  output logic                                pop_o,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [btlv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [2:0]                          out_tuser,
  output logic                                out_tlast
);

  localparam int LEN_W = (MAX_LENGTH_BYTES > 2) ? 8 * (MAX_LENGTH_BYTES - 1) : 8;
  localparam int CNT_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int LB_W  = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
  localparam int TB_W  = $clog2(MAX_TAG_BYTES + 1);
  localparam logic [CNT_W:0] CNT_MAX =
    {{(CNT_W + 1 - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam int PAD_W = btlv_pkg::OUT_TDATA_W - (8 + btlv_pkg::TAG_W
                                                  + btlv_pkg::LEN_OUT_W + 1 + 2);

  btlv_pkg::phase_t phase_r, phase_nxt, cur;

  logic [btlv_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [TB_W-1:0]            tb_r, tb_nxt;
  logic [LB_W-1:0]            lb_r, lb_nxt, lb_dec;
  logic [LEN_W-1:0]           la_r, la_nxt;
  logic [CNT_W-1:0]           cc_r, cc_nxt;
  logic [CNT_W:0]             cc_sum;
  logic                       ind_r, ind_nxt;
  logic                       pz_r, pz_nxt;

  logic [2:0]                     role;
  logic                           done;
  logic [1:0]                     err;
  logic [1:0]                     status;
  logic                           trunc;
  logic [CNT_W-1:0]               len_val;
  logic [btlv_pkg::LEN_OUT_W-1:0] len_sat;

  logic [7:0]                     byte_r;
  logic [2:0]                     role_r;
  logic [btlv_pkg::TAG_W-1:0]     tag_out_r;
  logic [btlv_pkg::LEN_OUT_W-1:0] len_out_r;
  logic                           ind_out_r;
  logic                           done_r;
  logic [1:0]                     status_r;
  logic                           out_valid_r, out_valid_nxt;

  assign pop_o = word_valid_i && (!out_valid_r || out_tready);
  assign cur   = word_i.start ? btlv_pkg::PH_TAG : phase_r;

  // per-byte decode and datapath updates
  always_comb begin
    role    = btlv_pkg::ROLE_DROP;
    done    = 1'b0;
    err     = btlv_pkg::ST_OK;
    tag_nxt = tag_r;
    tb_nxt  = tb_r;
    lb_nxt  = lb_r;
    lb_dec  = (lb_r != '0) ? lb_r - LB_W'(1) : lb_r;
    la_nxt  = la_r;
    cc_nxt  = cc_r;
    ind_nxt = ind_r;
    pz_nxt  = pz_r;
    cc_sum  = {1'b0, cc_r} + (pz_r ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    unique case (cur)
      btlv_pkg::PH_TAG: begin
        role    = btlv_pkg::ROLE_TAG;
        tag_nxt = btlv_pkg::TAG_W'(word_i.data);
        tb_nxt  = TB_W'(1);
        lb_nxt  = '0;
        la_nxt  = '0;
        cc_nxt  = '0;
        ind_nxt = 1'b0;
        pz_nxt  = 1'b0;
        if (word_i.long_tag && MAX_TAG_BYTES <= 1) begin
          err = btlv_pkg::ST_TAG_LONG;
        end
      end
      btlv_pkg::PH_TAGX: begin
        role    = btlv_pkg::ROLE_TAG;
        tag_nxt = {tag_r[btlv_pkg::TAG_W-9:0], word_i.data};
        tb_nxt  = tb_r + TB_W'(1);
        if (word_i.hi_bit && tb_nxt >= TB_W'(MAX_TAG_BYTES)) begin
          err = btlv_pkg::ST_TAG_LONG;
        end
      end
      btlv_pkg::PH_LEN: begin
        role   = btlv_pkg::ROLE_LEN;
        cc_nxt = '0;
        if (word_i.is_indef) begin
          ind_nxt = 1'b1;
          pz_nxt  = 1'b0;
        end else if (word_i.hi_bit) begin
          if (word_i.len_too_long) begin
            err = btlv_pkg::ST_LEN_LONG;
          end else begin
            lb_nxt = word_i.len_n[LB_W-1:0];
            la_nxt = '0;
          end
        end else begin
          la_nxt = LEN_W'(word_i.data);
          done   = word_i.is_zero;
        end
      end
      btlv_pkg::PH_LENX: begin
        role   = btlv_pkg::ROLE_LEN;
        la_nxt = LEN_W'({la_r, word_i.data});
        lb_nxt = lb_dec;
        if (lb_dec == '0) begin
          done = la_nxt == '0;
        end
      end
      btlv_pkg::PH_BODY: begin
        role   = btlv_pkg::ROLE_CONTENT;
        cc_nxt = cc_r + CNT_W'(1);
        done   = cc_nxt >= CNT_W'(la_r);
      end
      btlv_pkg::PH_INDEF: begin
        if (word_i.is_zero) begin
          role = btlv_pkg::ROLE_EOC;
          if (pz_r) begin
            done = 1'b1;
          end else begin
            pz_nxt = 1'b1;
          end
        end else begin
          role   = btlv_pkg::ROLE_CONTENT;
          cc_nxt = (cc_sum > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : cc_sum[CNT_W-1:0];
          pz_nxt = 1'b0;
        end
      end
      btlv_pkg::PH_DROP: begin
        role = btlv_pkg::ROLE_DROP;
      end
      default: begin
        role = btlv_pkg::ROLE_DROP;
      end
    endcase

    trunc   = (err == btlv_pkg::ST_OK) && !done && word_i.bend
              && (role != btlv_pkg::ROLE_DROP);
    status  = trunc ? btlv_pkg::ST_TRUNC : err;
    len_val = ind_nxt ? cc_nxt : CNT_W'(la_nxt);
    len_sat = (len_val > CNT_W'(btlv_pkg::LEN_OUT_MAX)) ? btlv_pkg::LEN_OUT_MAX
                                                          : btlv_pkg::LEN_OUT_W'(len_val);
  end

  // next state
  always_comb begin
    phase_nxt = cur;
    unique case (cur)
      btlv_pkg::PH_TAG: begin
        phase_nxt = word_i.long_tag ? btlv_pkg::PH_TAGX : btlv_pkg::PH_LEN;
      end
      btlv_pkg::PH_TAGX: begin
        phase_nxt = word_i.hi_bit ? btlv_pkg::PH_TAGX : btlv_pkg::PH_LEN;
      end
      btlv_pkg::PH_LEN: begin
        if (word_i.is_indef) begin
          phase_nxt = btlv_pkg::PH_INDEF;
        end else if (word_i.hi_bit) begin
          phase_nxt = btlv_pkg::PH_LENX;
        end else begin
          phase_nxt = btlv_pkg::PH_BODY;
        end
      end
      btlv_pkg::PH_LENX: begin
        phase_nxt = (lb_dec == '0) ? btlv_pkg::PH_BODY : btlv_pkg::PH_LENX;
      end
      btlv_pkg::PH_BODY:  phase_nxt = btlv_pkg::PH_BODY;
      btlv_pkg::PH_INDEF: phase_nxt = btlv_pkg::PH_INDEF;
      btlv_pkg::PH_DROP:  phase_nxt = btlv_pkg::PH_DROP;
      default:            phase_nxt = btlv_pkg::PH_DROP;
    endcase
    if (status != btlv_pkg::ST_OK) begin
      phase_nxt = btlv_pkg::PH_DROP;
    end else if (done) begin
      phase_nxt = btlv_pkg::PH_TAG;
    end
  end

  assign out_valid_nxt = pop_o || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= btlv_pkg::PH_TAG;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop_o) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      tag_r     <= tag_nxt;
      tb_r      <= tb_nxt;
      lb_r      <= lb_nxt;
      la_r      <= la_nxt;
      cc_r      <= cc_nxt;
      ind_r     <= ind_nxt;
      pz_r      <= pz_nxt;
      byte_r    <= word_i.data;
      role_r    <= role;
      done_r    <= done && (err == btlv_pkg::ST_OK);
      status_r  <= status;
      tag_out_r <= (done && err == btlv_pkg::ST_OK) ? tag_nxt : '0;
      len_out_r <= (done && err == btlv_pkg::ST_OK) ? len_sat : '0;
      ind_out_r <= done && (err == btlv_pkg::ST_OK) && ind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = role_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {{PAD_W{1'b0}}, status_r, ind_out_r, len_out_r, tag_out_r, byte_r};

endmodule

### rtl/ber_tlv_element_parser_core.sv
// Top level of the BER TLV element parser: front end, word queue, back end.
// Uses btlv_pkg, btlv_front, btlv_fifo, btlv_back.
//
// Usage:
//   Input stream: one encoded byte per word. in_tuser marks the byte that
//   starts a new element (abandons any element in progress), in_tlast marks
//   the last byte available in the buffer.
//   Output stream: one word per input byte, in order. out_tuser is the byte
//   role, out_tlast flags the final byte of a complete element, and out_tdata
//   carries the byte plus tag, content length, form and status (tag, length
//   and form are zero except on the final byte).
//   Throughput: one byte per cycle sustained while out_tready is high; the
//   parse state loop in the back end updates once per popped byte.
//   Path: an accepted byte is written into the two-word queue and then into
//   the output register that drives out_tvalid; under stall it waits in the queue.
//   Receiver stall: the output register holds, the queue fills, and in_tready
//   drops when the queue is full.
//   Reset: queue empty, out_tvalid low, parser expecting a tag byte.
//   After an error status, bytes come back with the discarded role until a
//   byte arrives with in_tuser set.
module ber_tlv_element_parser_core #(
  parameter int MAX_TAG_BYTES    = btlv_pkg::MAX_TAG_BYTES_DEF,
  parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int COUNT_BITS       = btlv_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tuser,   // [0] start_element
  input  logic                             in_tlast,   // buffer_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte, [31:8] tag_value, [47:32] content_length,
  // [48] indefinite_form, [50:49] status, [55:51] zero
  output logic [btlv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]                       out_tuser,  // [2:0] byte_role
  output logic                             out_tlast   // element_done
);

  btlv_pkg::cls_t cls_word;
  btlv_pkg::cls_t head_word;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;

  btlv_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .byte_i (in_tdata),
    .start_i(in_tuser),
    .bend_i (in_tlast),
    .word_o (cls_word)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  btlv_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .wdata_i(cls_word),
    .pop_i  (pop),
    .rdata_o(head_word),
    .full_o (q_full),
    .valid_o(q_valid)
  );

  btlv_back #(
    .MAX_TAG_BYTES   (MAX_TAG_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .word_i      (head_word),
    .word_valid_i(q_valid),
    .pop_o       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[50:49] == btlv_pkg::ST_OK)
    else $error("element done with error status");

  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == btlv_pkg::ROLE_DROP |->
      !out_tlast && out_tdata[50:49] == btlv_pkg::ST_OK)
    else $error("discarded byte carries done or status");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready && !push)
    else $error("queue written while full");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && (!out_tvalid || out_tready))
    else $error("queue popped without room or data");

endmodule
